// ----- sv/pas_pkg.sv -----
// Shared constants, types and the control-store contents of the alarm scheduler.
package pas_pkg;

  localparam int ALARM_SLOTS_DEF   = 8;
  localparam int CATCHUP_LIMIT_DEF = 4;

  localparam int KIND_W = 2;
  localparam int SLOT_W = 3;
  localparam int TIME_W = 64;

  localparam int RESULT_CAP = 32;
  localparam int NRES_W     = $clog2(RESULT_CAP + 1);

  localparam logic [KIND_W-1:0] KIND_TICK     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ONESHOT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PERIODIC = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CANCEL   = 2'd3;

  localparam int STEP_W     = 3;
  localparam int STEP_COUNT = 1 << STEP_W;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_FETCH = 3'd0;
  localparam step_t STEP_READ  = 3'd1;
  localparam step_t STEP_LOAD  = 3'd2;
  localparam step_t STEP_CHECK = 3'd3;
  localparam step_t STEP_FIRE  = 3'd4;
  localparam step_t STEP_NEXT  = 3'd5;
  localparam step_t STEP_FLUSH = 3'd6;
  localparam step_t STEP_SPARE = 3'd7;

  typedef enum logic [2:0] {
    JC_SEQ     = 3'd0,
    JC_ALWAYS  = 3'd1,
    JC_NO_TICK = 3'd2,
    JC_NOT_DUE = 3'd3,
    JC_MORE    = 3'd4
  } jcond_t;

  typedef struct packed {
    logic   accept;
    logic   rd;
    logic   load;
    logic   fire;
    logic   wb;
    logic   advance;
    logic   flush;
    jcond_t jcond;
    step_t  target;
  } ctl_t;

  typedef struct packed {
    logic tick_acc;
    logic due;
    logic more;
    logic hold;
  } stat_t;

  localparam ctl_t [STEP_COUNT-1:0] UCODE = '{
    // STEP_SPARE
    '{accept: 1'b0, rd: 1'b0, load: 1'b0, fire: 1'b0, wb: 1'b0, advance: 1'b0,
      flush: 1'b0, jcond: JC_ALWAYS, target: STEP_FETCH},
    // STEP_FLUSH
    '{accept: 1'b0, rd: 1'b0, load: 1'b0, fire: 1'b0, wb: 1'b0, advance: 1'b0,
      flush: 1'b1, jcond: JC_ALWAYS, target: STEP_FETCH},
    // STEP_NEXT
    '{accept: 1'b0, rd: 1'b0, load: 1'b0, fire: 1'b0, wb: 1'b1, advance: 1'b1,
      flush: 1'b0, jcond: JC_MORE, target: STEP_READ},
    // STEP_FIRE
    '{accept: 1'b0, rd: 1'b0, load: 1'b0, fire: 1'b1, wb: 1'b0, advance: 1'b0,
      flush: 1'b0, jcond: JC_ALWAYS, target: STEP_CHECK},
    // STEP_CHECK
    '{accept: 1'b0, rd: 1'b0, load: 1'b0, fire: 1'b0, wb: 1'b0, advance: 1'b0,
      flush: 1'b0, jcond: JC_NOT_DUE, target: STEP_NEXT},
    // STEP_LOAD
    '{accept: 1'b0, rd: 1'b0, load: 1'b1, fire: 1'b0, wb: 1'b0, advance: 1'b0,
      flush: 1'b0, jcond: JC_SEQ, target: STEP_CHECK},
    // STEP_READ
    '{accept: 1'b0, rd: 1'b1, load: 1'b0, fire: 1'b0, wb: 1'b0, advance: 1'b0,
      flush: 1'b0, jcond: JC_SEQ, target: STEP_LOAD},
    // STEP_FETCH
    '{accept: 1'b1, rd: 1'b0, load: 1'b0, fire: 1'b0, wb: 1'b0, advance: 1'b0,
      flush: 1'b0, jcond: JC_NO_TICK, target: STEP_FETCH}
  };

endpackage

// ----- sv/pas_if.sv -----
// Valid/ready channel interfaces for the request and firing streams.
interface pas_in_if;
  logic                         valid;
  logic                         ready;
  logic [pas_pkg::KIND_W-1:0]   kind;
  logic [pas_pkg::SLOT_W-1:0]   slot;
  logic [pas_pkg::TIME_W-1:0]   time_value;
  logic [pas_pkg::TIME_W-1:0]   period_value;

  modport source (output valid, kind, slot, time_value, period_value, input ready);
  modport sink   (input valid, kind, slot, time_value, period_value, output ready);
endinterface

interface pas_out_if;
  logic                       valid;
  logic                       ready;
  logic [pas_pkg::SLOT_W-1:0] fired_slot;
  logic                       last;

  modport source (output valid, fired_slot, last, input ready);
  modport sink   (input valid, fired_slot, last, output ready);
endinterface

// ----- sv/periodic_alarm_scheduler.sv -----
// Periodic alarm scheduler: time counter, slot table and firing datapath.
//
// Set and cancel beats are taken in the fetch step. A tick walks the slot
// table and stalls while the firing stream is stalled: the microprogram
// spends four steps per slot (read the slot RAMs, load, check, write back)
// and two per firing (fire, check again), the slot RAMs having one
// registered read port; the walk stops early once a tick has given 32
// firings. The last firing of a tick is held one beat so it can carry the
// last flag. A slot fires at most CATCHUP_LIMIT times per tick and a tick
// gives at most 32 firings; the rest wait for later ticks. Sets and cancels
// naming a slot beyond the table are dropped.
module periodic_alarm_scheduler #(
  parameter int ALARM_SLOTS   = pas_pkg::ALARM_SLOTS_DEF,
  parameter int CATCHUP_LIMIT = pas_pkg::CATCHUP_LIMIT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  pas_in_if.sink    alarm_in,
  pas_out_if.source alarm_out
);

  localparam int SW    = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
  localparam int CNT_W = $clog2(CATCHUP_LIMIT + 1);
  localparam int XW    = SW + pas_pkg::SLOT_W;
  localparam int TW    = pas_pkg::TIME_W;

  pas_pkg::ctl_t  ctl;
  pas_pkg::stat_t stat;

  logic [TW-1:0]                     now;
  logic [SW-1:0]                     s;
  logic [pas_pkg::NRES_W-1:0]        nres;
  logic [CNT_W-1:0]                  count;
  logic [TW-1:0]                     ft;
  logic [TW-1:0]                     per;
  logic [ALARM_SLOTS-1:0]            armed;
  logic                              pend_valid;
  logic [pas_pkg::SLOT_W-1:0]        pend_slot;
  logic                              out_valid;
  logic [pas_pkg::SLOT_W-1:0]        out_slot;
  logic                              out_last;

  logic          acc;
  logic          tick_acc;
  logic          in_range;
  logic          set_go;
  logic          cancel_go;
  logic [XW-1:0] slot_ext;
  logic [SW-1:0] set_addr;
  logic          out_free;
  logic          hold;
  logic          fire_go;
  logic          flush_go;
  logic          due;
  logic          more;

  logic          ft_we;
  logic [SW-1:0] ram_waddr;
  logic [TW-1:0] ft_wdata;
  logic [TW-1:0] per_wdata;
  logic [TW-1:0] ft_rdata;
  logic [TW-1:0] per_rdata;

  pas_useq u_useq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  pas_ram #(.WIDTH(TW), .DEPTH(ALARM_SLOTS)) u_ft_ram (
    .clk   (clk),
    .we    (ft_we),
    .waddr (ram_waddr),
    .wdata (ft_wdata),
    .raddr (s),
    .rdata (ft_rdata)
  );

  pas_ram #(.WIDTH(TW), .DEPTH(ALARM_SLOTS)) u_per_ram (
    .clk   (clk),
    .we    (set_go),
    .waddr (ram_waddr),
    .wdata (per_wdata),
    .raddr (s),
    .rdata (per_rdata)
  );

  assign alarm_in.ready       = ctl.accept;
  assign alarm_out.valid      = out_valid;
  assign alarm_out.fired_slot = out_slot;
  assign alarm_out.last       = out_last;

  assign acc       = ctl.accept && alarm_in.valid;
  assign tick_acc  = acc && (alarm_in.kind == pas_pkg::KIND_TICK);
  assign slot_ext  = XW'(alarm_in.slot);
  assign set_addr  = slot_ext[SW-1:0];
  assign in_range  = slot_ext < XW'(ALARM_SLOTS);
  assign set_go    = acc && in_range && ((alarm_in.kind == pas_pkg::KIND_ONESHOT) ||
                                         (alarm_in.kind == pas_pkg::KIND_PERIODIC));
  assign cancel_go = acc && in_range && (alarm_in.kind == pas_pkg::KIND_CANCEL);

  assign ft_we     = set_go || ctl.wb;
  assign ram_waddr = ctl.wb ? s : set_addr;
  assign ft_wdata  = ctl.wb ? ft :
                     (alarm_in.kind == pas_pkg::KIND_ONESHOT) ? now + alarm_in.time_value :
                     alarm_in.time_value;
  assign per_wdata = (alarm_in.kind == pas_pkg::KIND_ONESHOT) ? '0 : alarm_in.period_value;

  assign out_free = !out_valid || alarm_out.ready;
  assign hold     = (ctl.fire || ctl.flush) && pend_valid && !out_free;
  assign fire_go  = ctl.fire && !hold;
  assign flush_go = ctl.flush && !hold && pend_valid;

  assign due  = armed[s] && (ft < now) && (count < CNT_W'(CATCHUP_LIMIT)) &&
                (nres < pas_pkg::NRES_W'(pas_pkg::RESULT_CAP));
  assign more = (s != SW'(ALARM_SLOTS - 1)) &&
                (nres != pas_pkg::NRES_W'(pas_pkg::RESULT_CAP));

  assign stat = '{tick_acc: tick_acc, due: due, more: more, hold: hold};

  always_ff @(posedge clk) begin
    if (rst) begin
      now        <= '0;
      armed      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      s          <= '0;
      nres       <= '0;
      count      <= '0;
    end else begin
      if (tick_acc) begin
        now  <= now + TW'(1);
        s    <= '0;
        nres <= '0;
      end
      if (ctl.advance && more) begin
        s <= s + SW'(1);
      end
      if (ctl.rd) begin
        count <= '0;
      end
      if (set_go) begin
        armed[set_addr] <= 1'b1;
      end
      if (cancel_go) begin
        armed[set_addr] <= 1'b0;
      end
      if ((fire_go && pend_valid) || flush_go) begin
        out_valid <= 1'b1;
      end else if (alarm_out.ready) begin
        out_valid <= 1'b0;
      end
      if (fire_go) begin
        nres       <= nres + pas_pkg::NRES_W'(1);
        count      <= count + CNT_W'(1);
        pend_valid <= 1'b1;
        if (per == '0) begin
          armed[s] <= 1'b0;
        end
      end
      if (flush_go) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ft  <= ft_rdata;
      per <= per_rdata;
    end else if (fire_go && per != '0) begin
      ft <= ft + per;
    end
    if (fire_go) begin
      pend_slot <= pas_pkg::SLOT_W'(s);
      if (pend_valid) begin
        out_slot <= pend_slot;
        out_last <= 1'b0;
      end
    end
    if (flush_go) begin
      out_slot <= pend_slot;
      out_last <= 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_pend_at_fetch: assert property (@(posedge clk) disable iff (rst)
    ctl.accept |-> !pend_valid)
    else $error("firing still held while taking a new beat");

  a_result_cap: assert property (@(posedge clk) disable iff (rst)
    nres <= pas_pkg::NRES_W'(pas_pkg::RESULT_CAP))
    else $error("firing count per tick over its cap");

  a_catchup_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CATCHUP_LIMIT))
    else $error("catch-up count over its limit");

  a_fire_entry_due: assert property (@(posedge clk) disable iff (rst)
    (ctl.fire && !$past(ctl.fire)) |-> $past(due))
    else $error("fire step entered for a slot not due");
`endif

endmodule

// ----- sv/pas_ram.sv -----
// Generic simple dual-port RAM with registered read.
module pas_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/pas_useq.sv -----
// Microcode sequencer: step counter, control store and jump logic.
module pas_useq (
  input  logic           clk,
  input  logic           rst,
  input  pas_pkg::stat_t stat,
  output pas_pkg::ctl_t  ctl
);

  pas_pkg::step_t step;
  pas_pkg::step_t step_next;

  assign ctl = pas_pkg::UCODE[step];

  always_comb begin
    step_next = step + pas_pkg::step_t'(1);
    case (ctl.jcond)
      pas_pkg::JC_SEQ:     step_next = step + pas_pkg::step_t'(1);
      pas_pkg::JC_ALWAYS:  step_next = ctl.target;
      pas_pkg::JC_NO_TICK: step_next = stat.tick_acc ? step + pas_pkg::step_t'(1) : ctl.target;
      pas_pkg::JC_NOT_DUE: step_next = stat.due ? step + pas_pkg::step_t'(1) : ctl.target;
      pas_pkg::JC_MORE:    step_next = stat.more ? ctl.target : step + pas_pkg::step_t'(1);
      default:             step_next = pas_pkg::STEP_FETCH;
    endcase
    if (stat.hold) begin
      step_next = step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= pas_pkg::STEP_FETCH;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ----- tb/periodic_alarm_scheduler_tb.sv -----
// Self-checking testbench for the periodic alarm scheduler, with an internal firing predictor.
module periodic_alarm_scheduler_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS   = pas_pkg::ALARM_SLOTS_DEF;
  localparam int CATCHUP = pas_pkg::CATCHUP_LIMIT_DEF;

  typedef logic [pas_pkg::KIND_W-1:0] kind_t;
  typedef logic [pas_pkg::SLOT_W-1:0] slot_t;
  typedef logic [pas_pkg::TIME_W-1:0] time_t;

  typedef struct packed {
    slot_t slot;
    logic  last;
  } firing_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pas_in_if  alarm_in ();
  pas_out_if alarm_out ();

  periodic_alarm_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .alarm_in  (alarm_in),
    .alarm_out (alarm_out)
  );

  // Predicted scheduler state
  time_t           now_ticks;
  logic            armed [SLOTS];
  time_t           fire_at [SLOTS];
  time_t           reload [SLOTS];
  firing_t         due_firings [$];
  firing_t         next_firing;

  int errors         = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  always @(negedge clk) begin
    alarm_out.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Firing order follows slot order, capped per slot and per tick.
  task automatic apply_request(input kind_t kind, input slot_t slot,
                               input time_t tval, input time_t pval);
    slot_t fired [pas_pkg::RESULT_CAP];
    int    n;
    int    cnt;
    int    s;
    int    i;
    firing_t f;
    n = 0;
    case (kind)
      pas_pkg::KIND_ONESHOT: begin
        fire_at[slot] = now_ticks + tval;
        reload[slot]  = '0;
        armed[slot]   = 1'b1;
      end
      pas_pkg::KIND_PERIODIC: begin
        fire_at[slot] = tval;
        reload[slot]  = pval;
        armed[slot]   = 1'b1;
      end
      pas_pkg::KIND_CANCEL: begin
        armed[slot] = 1'b0;
      end
      default: begin
        now_ticks = now_ticks + 64'd1;
        for (s = 0; s < SLOTS && n < pas_pkg::RESULT_CAP; s++) begin
          cnt = 0;
          while (armed[s] && fire_at[s] < now_ticks && cnt < CATCHUP &&
                 n < pas_pkg::RESULT_CAP) begin
            fired[n] = s[pas_pkg::SLOT_W-1:0];
            n++;
            cnt++;
            if (reload[s] != '0) fire_at[s] = fire_at[s] + reload[s];
            else armed[s] = 1'b0;
          end
        end
        for (i = 0; i < n; i++) begin
          f.slot = fired[i];
          f.last = (i == n - 1);
          due_firings.push_back(f);
        end
      end
    endcase
  endtask

  // Presents one beat at the falling edge; valid is left high on return.
  task automatic send_request(input kind_t kind, input slot_t slot,
                              input time_t tval, input time_t pval);
    while ($urandom_range(99) < send_idle_pct) begin
      alarm_in.valid <= 1'b0;
      @(negedge clk);
    end
    alarm_in.valid        <= 1'b1;
    alarm_in.kind         <= kind;
    alarm_in.slot         <= slot;
    alarm_in.time_value   <= tval;
    alarm_in.period_value <= pval;
    do @(posedge clk); while (!alarm_in.ready);
    apply_request(kind, slot, tval, pval);
    @(negedge clk);
  endtask

  function automatic time_t rand64();
    return {$urandom, $urandom};
  endfunction

  always @(posedge clk) begin
    if (!rst && alarm_out.valid && alarm_out.ready) begin
      if (due_firings.size() == 0) begin
        $display("%0t: unexpected firing: expected none actual slot %0d last %0b", $time,
                 alarm_out.fired_slot, alarm_out.last);
        errors++;
      end else begin
        next_firing = due_firings.pop_front();
        if (alarm_out.fired_slot !== next_firing.slot) begin
          $display("%0t: fired_slot mismatch: expected %0d actual %0d", $time,
                   next_firing.slot, alarm_out.fired_slot);
          errors++;
        end
        if (alarm_out.last !== next_firing.last) begin
          $display("%0t: last mismatch: expected %0b actual %0b", $time,
                   next_firing.last, alarm_out.last);
          errors++;
        end
      end
    end
  end

  task automatic test_idle_tick();
    send_request(pas_pkg::KIND_TICK, 3'd7, rand64(), rand64());
  endtask

  task automatic test_one_shot();
    send_request(pas_pkg::KIND_ONESHOT, 3'd0, 64'd0, '1);
    send_request(pas_pkg::KIND_TICK, 3'd0, '0, '0);
  endtask

  // Delay of all ones lands one behind now; zero period acts as a one-shot.
  task automatic test_wrap_and_zero_period();
    send_request(pas_pkg::KIND_ONESHOT, 3'd7, '1, 64'd0);
    send_request(pas_pkg::KIND_PERIODIC, 3'd3, 64'd0, 64'd0);
    send_request(pas_pkg::KIND_PERIODIC, 3'd5, 64'd0, '1);
    send_request(pas_pkg::KIND_TICK, 3'd0, '1, '1);
  endtask

  task automatic test_cancel();
    send_request(pas_pkg::KIND_PERIODIC, 3'd1, '1, 64'd1);
    send_request(pas_pkg::KIND_CANCEL, 3'd1, rand64(), rand64());
    send_request(pas_pkg::KIND_CANCEL, 3'd5, '0, '0);
    send_request(pas_pkg::KIND_TICK, 3'd0, '0, '0);
    send_request(pas_pkg::KIND_TICK, 3'd0, '0, '0);
  endtask

  // All slots lagging: per-slot cap and tick cap both hit, rest carries over.
  task automatic test_catch_up();
    int i;
    send_request(pas_pkg::KIND_TICK, 3'd0, '0, '0);
    for (i = 0; i < SLOTS; i++) begin
      send_request(pas_pkg::KIND_PERIODIC, i[pas_pkg::SLOT_W-1:0], 64'd0, 64'd1);
    end
    repeat (3) send_request(pas_pkg::KIND_TICK, 3'd0, '0, '0);
  endtask

  task automatic test_random_traffic();
    int idle_pct [4]  = '{0, 75, 0, 9};
    int stall_pct [4] = '{0, 0, 75, 9};
    int p;
    int sel;
    int r;
    int q;
    kind_t kind;
    time_t tval;
    time_t pval;
    for (p = 0; p < 4; p++) begin
      send_idle_pct  = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      repeat (63) begin
        sel  = $urandom_range(99);
        r    = $urandom_range(9);
        q    = $urandom_range(9);
        tval = rand64();
        pval = rand64();
        if (sel < 40) begin
          kind = pas_pkg::KIND_TICK;
        end else if (sel < 60) begin
          kind = pas_pkg::KIND_ONESHOT;
          if (r < 7) tval = time_t'($urandom_range(0, 5));
          else if (r < 8) tval = '1 - time_t'($urandom_range(0, 3));
        end else if (sel < 85) begin
          kind = pas_pkg::KIND_PERIODIC;
          if (r < 7) tval = now_ticks - time_t'($urandom_range(0, 8)) +
                            time_t'($urandom_range(0, 4));
          else if (r == 9) tval = '1;
          if (q < 6) pval = time_t'($urandom_range(0, 3));
          else if (q == 9) pval = '1 - time_t'($urandom_range(0, 2));
        end else begin
          kind = pas_pkg::KIND_CANCEL;
        end
        send_request(kind, slot_t'($urandom_range(7)), tval, pval);
      end
    end
  endtask

  initial begin
    int i;
    alarm_in.valid        = 1'b0;
    alarm_in.kind         = pas_pkg::KIND_TICK;
    alarm_in.slot         = '0;
    alarm_in.time_value   = '0;
    alarm_in.period_value = '0;
    now_ticks = '0;
    for (i = 0; i < SLOTS; i++) begin
      armed[i]   = 1'b0;
      fire_at[i] = '0;
      reload[i]  = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_idle_tick();
    test_one_shot();
    test_wrap_and_zero_period();
    test_cancel();
    test_catch_up();
    test_random_traffic();

    alarm_in.valid <= 1'b0;
    while (due_firings.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
